/* rtl/chacha20_stream_cipher_core_defines.svh */
// assertion macros used by the cipher core controller
`ifndef CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH

// same-cycle implication, checking suspended while reset is high
`define CHACHA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chacha core check failed");

// next-cycle implication, checking suspended while reset is high
`define CHACHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chacha core check failed");

`endif

/* rtl/chacha_pkg.sv */
// shared types, constants and command structs of the chacha20 cipher core
`default_nettype none

package chacha_pkg;

  localparam int DOUBLE_ROUNDS_DEFAULT = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE1 = 3'd6;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted input word
    logic ctr_load;   // message start: counter from config
    logic pos_clear;
    logic load;       // working state from constants, key, counter, nonce
    logic half1;      // first half of quarter round on column 0
    logic half2;      // second half, then rotate columns
    logic diag;       // rows rotated so diagonals line up as columns
    logic undiag;
    logic ffwd;       // feed-forward add, counter increment
    logic emit;       // result register load, position advance
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_zero;
    logic item_last;
  } stat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

endpackage

`default_nettype wire

/* rtl/chacha_dp.sv */
// datapath: config registers, working state, half quarter-round unit, byte output
`default_nettype none

module chacha_dp (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [chacha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [chacha_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire  chacha_pkg::in_t                data,
  input  wire  chacha_pkg::cmd_t               cmd,
  output chacha_pkg::stat_t                    stat,
  output chacha_pkg::out_t                     result
);
  import chacha_pkg::*;

  logic [63:0] key [4];
  logic [31:0] init_ctr;
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;

  logic [31:0] ctr;
  logic [5:0]  pos;
  in_t         item;

  // working state; after the feed-forward it is the keystream block
  logic [31:0] w [16];
  logic [31:0] w_next [16];
  logic [31:0] init_w [16];

  logic [31:0] a1, b1, c1, d1;
  logic [31:0] a2, b2, c2, d2;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0]   <= '0;
      key[1]   <= '0;
      key[2]   <= '0;
      key[3]   <= '0;
      init_ctr <= '0;
      nonce_lo <= '0;
      nonce_hi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0:   key[0]   <= cfg_data;
        REG_KEY1:   key[1]   <= cfg_data;
        REG_KEY2:   key[2]   <= cfg_data;
        REG_KEY3:   key[3]   <= cfg_data;
        REG_CTR:    init_ctr <= cfg_data[31:0];
        REG_NONCE0: nonce_lo <= cfg_data;
        REG_NONCE1: nonce_hi <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    init_w[4]  = key[0][31:0];
    init_w[5]  = key[0][63:32];
    init_w[6]  = key[1][31:0];
    init_w[7]  = key[1][63:32];
    init_w[8]  = key[2][31:0];
    init_w[9]  = key[2][63:32];
    init_w[10] = key[3][31:0];
    init_w[11] = key[3][63:32];
    init_w[12] = ctr;
    init_w[13] = nonce_lo[31:0];
    init_w[14] = nonce_lo[63:32];
    init_w[15] = nonce_hi;
  end

  // half quarter rounds always work on column 0
  always_comb begin
    a1 = w[0] + w[4];
    d1 = rotl32(w[12] ^ a1, 16);
    c1 = w[8] + d1;
    b1 = rotl32(w[4] ^ c1, 12);
    a2 = w[0] + w[4];
    d2 = rotl32(w[12] ^ a2, 8);
    c2 = w[8] + d2;
    b2 = rotl32(w[4] ^ c2, 7);
  end

  always_comb begin
    w_next = w;
    if (cmd.load) begin
      w_next = init_w;
    end else if (cmd.half1) begin
      w_next[0]  = a1;
      w_next[4]  = b1;
      w_next[8]  = c1;
      w_next[12] = d1;
    end else if (cmd.half2) begin
      // finished column goes to the back, next column moves to the front
      w_next[0]  = w[1];  w_next[1]  = w[2];  w_next[2]  = w[3];  w_next[3]  = a2;
      w_next[4]  = w[5];  w_next[5]  = w[6];  w_next[6]  = w[7];  w_next[7]  = b2;
      w_next[8]  = w[9];  w_next[9]  = w[10]; w_next[10] = w[11]; w_next[11] = c2;
      w_next[12] = w[13]; w_next[13] = w[14]; w_next[14] = w[15]; w_next[15] = d2;
    end else if (cmd.diag) begin
      // row r rotated left by r words
      w_next[4]  = w[5];  w_next[5]  = w[6];  w_next[6]  = w[7];  w_next[7]  = w[4];
      w_next[8]  = w[10]; w_next[9]  = w[11]; w_next[10] = w[8];  w_next[11] = w[9];
      w_next[12] = w[15]; w_next[13] = w[12]; w_next[14] = w[13]; w_next[15] = w[14];
    end else if (cmd.undiag) begin
      w_next[4]  = w[7];  w_next[5]  = w[4];  w_next[6]  = w[5];  w_next[7]  = w[6];
      w_next[8]  = w[10]; w_next[9]  = w[11]; w_next[10] = w[8];  w_next[11] = w[9];
      w_next[12] = w[13]; w_next[13] = w[14]; w_next[14] = w[15]; w_next[15] = w[12];
    end else if (cmd.ffwd) begin
      for (int i = 0; i < 16; i++) begin
        w_next[i] = w[i] + init_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
      pos <= '0;
    end else begin
      if (cmd.ctr_load) begin
        ctr <= init_ctr;
      end else if (cmd.ffwd) begin
        ctr <= ctr + 32'd1;
      end
      if (cmd.pos_clear) begin
        pos <= '0;
      end else if (cmd.emit) begin
        pos <= pos + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= data;
    end
  end

  assign ks_word = w[pos[5:2]];
  assign ks_byte = 8'(ks_word >> {pos[1:0], 3'b000});

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_byte <= item.in_byte ^ ks_byte;
      result.last_out <= item.last_byte;
    end
  end

  assign stat.pos_zero  = (pos == 6'd0);
  assign stat.item_last = item.last_byte;

endmodule

`default_nettype wire

/* rtl/chacha_ctrl.sv */
// controller: sequences block generation and byte delivery
`default_nettype none
`include "chacha20_stream_cipher_core_defines.svh"

module chacha_ctrl #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEFAULT
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                data_valid,
  output logic               data_stall,
  output logic               result_valid,
  input  wire                result_stall,
  input  wire  chacha_pkg::stat_t stat,
  output chacha_pkg::cmd_t   cmd
);
  import chacha_pkg::*;

  localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_HALF1  = 4'd3;
  localparam logic [3:0] S_HALF2  = 4'd4;
  localparam logic [3:0] S_DIAG   = 4'd5;
  localparam logic [3:0] S_UNDIAG = 4'd6;
  localparam logic [3:0] S_FFWD   = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;

  logic [3:0]       state, state_next;
  logic [1:0]       col, col_next;
  logic             diag_pass, diag_pass_next;
  logic [RND_W-1:0] rnd, rnd_next;
  logic             fresh, fresh_next;
  logic             out_free;

  assign out_free   = !result_valid || !result_stall;
  assign data_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    col_next       = col;
    diag_pass_next = diag_pass;
    rnd_next       = rnd;
    fresh_next     = fresh;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (data_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (fresh) begin
          cmd.ctr_load  = 1'b1;
          cmd.pos_clear = 1'b1;
          fresh_next    = 1'b0;
        end
        state_next = (fresh || stat.pos_zero) ? S_LOAD : S_EMIT;
      end
      S_LOAD: begin
        cmd.load       = 1'b1;
        col_next       = '0;
        diag_pass_next = 1'b0;
        rnd_next       = '0;
        state_next     = S_HALF1;
      end
      S_HALF1: begin
        cmd.half1  = 1'b1;
        state_next = S_HALF2;
      end
      S_HALF2: begin
        cmd.half2 = 1'b1;
        col_next  = col + 2'd1;
        if (col == 2'd3) begin
          state_next = diag_pass ? S_UNDIAG : S_DIAG;
        end else begin
          state_next = S_HALF1;
        end
      end
      S_DIAG: begin
        cmd.diag       = 1'b1;
        diag_pass_next = 1'b1;
        state_next     = S_HALF1;
      end
      S_UNDIAG: begin
        cmd.undiag     = 1'b1;
        diag_pass_next = 1'b0;
        // round count returns to zero after the last double round
        rnd_next       = (rnd == RND_LAST) ? '0 : rnd + RND_W'(1);
        state_next     = (rnd == RND_LAST) ? S_FFWD : S_HALF1;
      end
      S_FFWD: begin
        cmd.ffwd   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          fresh_next = stat.item_last;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      col          <= '0;
      diag_pass    <= 1'b0;
      rnd          <= '0;
      fresh        <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      diag_pass <= diag_pass_next;
      rnd       <= rnd_next;
      fresh     <= fresh_next;
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `CHACHA_ASSERT_NOW(a_emit_needs_room, clk, rst, cmd.emit, out_free)
  `CHACHA_ASSERT_NOW(a_valid_from_emit, clk, rst, $rose(result_valid), $past(state == S_EMIT))
  `CHACHA_ASSERT_NEXT(a_accept_starts, clk, rst, data_valid && !data_stall, state == S_START)
  `CHACHA_ASSERT_NOW(a_round_bound, clk, rst, state != S_IDLE, rnd <= RND_LAST)

endmodule

`default_nettype wire

/* rtl/chacha20_stream_cipher_core.sv */
// top level of the chacha20 byte-stream cipher core
// ChaCha20 in the 96-bit-nonce layout, one byte per word: each data word's
// byte is XORed with the next keystream byte and returned with its last flag.
// Key, initial counter and nonce are written through the cfg port (index 0..3
// key bytes 0-31 little-endian, 4 initial counter, 5..6 nonce); a write is
// taken every cycle but must only happen while the core is idle. Bytes are
// handled one at a time: a byte inside a block passes through accept, start
// and emit; a byte at a block boundary also builds a 64-byte block between
// start and emit. The block is built by the single shared half quarter-round
// unit, which does two dependent adds per step, with a row rotation before
// and after every diagonal round. A new data word is taken while the
// previous result still waits in the output register. After a word flagged
// last, the next byte starts a new message at the configured counter.
`default_nettype none

module chacha20_stream_cipher_core #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst,
  // data words in
  input  wire                                data_valid,
  output logic                               data_stall,
  input  wire  chacha_pkg::in_t              data,
  // result words out
  output logic                               result_valid,
  input  wire                                result_stall,
  output chacha_pkg::out_t                   result,
  // configuration writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [chacha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [chacha_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import chacha_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // registers always take a write
  assign cfg_ready = 1'b1;

  chacha_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  chacha_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .data      (data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

`default_nettype wire
